// ----- hdl/htb_pkg.sv -----
// ----------------------------------------------------------------------------
// htb_pkg
// Shared constants and types for the tree builder.
// ----------------------------------------------------------------------------
package htb_pkg;
	localparam int SYMBOLS_DEF     = 256;
	localparam int FREQ_BITS_DEF   = 32;
	localparam int WEIGHT_BITS_DEF = 40;
	localparam int IDX_W           = 9;
	localparam int FREQ_W          = 32;
	localparam int WOUT_W          = 40;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_NODE  = 1'b1;

	// link entry: everything but the weight
	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             internal;
		logic [IDX_W-1:0] parent;
		logic             has_parent;
		logic             side;
	} link_t;
endpackage

// ----- hdl/htb_link_mem.sv -----
// ----------------------------------------------------------------------------
// htb_link_mem
// Child, parent and side store; one write port, one registered read port.
// Entries are zeroed by the builder's pass after reset and again at each
// build start.
// ----------------------------------------------------------------------------
module htb_link_mem
	import htb_pkg::*;
#(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  link_t         wdata,
	input  logic [AW-1:0] raddr,
	output link_t         rdata
);
	link_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/htb_weight_mem.sv -----
// ----------------------------------------------------------------------------
// htb_weight_mem
// Weight store; one write port, one registered read port.
// ----------------------------------------------------------------------------
module htb_weight_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int W     = 40
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/huffman_tree_builder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_builder
// Loads leaf weights, builds a Huffman tree in place, answers node reads.
// ----------------------------------------------------------------------------
// channel | dir | handshake                | payload
// in      | in  | in_valid / in_ready      | operation node_id frequency last
// out     | out | out_valid / out_ready    | kind tree_valid root_index ...
//
// A load beat writes the weight store as it is accepted; input is held while a result waits untaken.
// A read beat reads both memories at its edge; the output register loads on
// the next edge and input is held for that cycle.
// After reset a clearing pass over all 2*SYMBOLS entries zeroes both stores.
// A last load starts a build: a clear pass over 2*SYMBOLS entries, then per
// merge a scan of the weights below the next free slot through the weight read
// port and three write steps; input is held off until the build report is taken.
// ----------------------------------------------------------------------------
module huffman_tree_builder
	import htb_pkg::*;
#(
	parameter int SYMBOLS     = SYMBOLS_DEF,
	parameter int FREQ_BITS   = FREQ_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [IDX_W-1:0]     node_id,
	input  logic [FREQ_BITS-1:0] frequency,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output logic                 tree_valid,
	output logic [IDX_W-1:0]     root_index,
	output logic [IDX_W-1:0]     left_child,
	output logic [IDX_W-1:0]     right_child,
	output logic                 has_children,
	output logic [IDX_W-1:0]     parent_index,
	output logic                 has_parent,
	output logic                 is_right_child,
	output logic [WOUT_W-1:0]    node_weight
);
	localparam int NODES = 2 * SYMBOLS;
	localparam int AW    = $clog2(NODES);
	localparam int CW    = AW + 1;
	localparam int W     = WEIGHT_BITS;
	localparam logic [W-1:0] WMAX = {W{1'b1}};

	// sequencer states
	localparam logic [2:0] ST_INIT  = 3'd0; // post-reset store clear
	localparam logic [2:0] ST_RUN   = 3'd1; // loads and reads
	localparam logic [2:0] ST_CLR   = 3'd2; // build start clear
	localparam logic [2:0] ST_SCAN  = 3'd3; // min-two search
	localparam logic [2:0] ST_M0    = 3'd4; // write new node
	localparam logic [2:0] ST_M1    = 3'd5; // write first child
	localparam logic [2:0] ST_M2    = 3'd6; // write second child
	localparam logic [2:0] ST_RPT   = 3'd7; // build report

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;       // sweep / scan address
	logic [CW-1:0] slot_q;      // next free node
	logic          merged_q;
	logic [AW-1:0] root_q;
	// scan pipeline: address issued last cycle
	logic          rd_v_s1;
	logic [AW-1:0] rd_a_s1;
	logic          f1_q, f2_q;
	logic [W-1:0]  w1_q, w2_q;
	logic [AW-1:0] i1_q, i2_q;

	// memory ports
	logic          w_we, l_we;
	logic [AW-1:0] w_wa, l_wa, w_ra, l_ra;
	logic [W-1:0]  w_wd, w_rd;
	link_t         l_wd, l_rd;

	htb_weight_mem #(.DEPTH(NODES), .AW(AW), .W(W)) u_wmem (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
		.raddr(w_ra), .rdata(w_rd)
	);
	htb_link_mem #(.DEPTH(NODES), .AW(AW)) u_lmem (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
		.raddr(l_ra), .rdata(l_rd)
	);

	// output register and pending read
	logic          ov_q;
	logic          rd_pend_s1;
	logic          rd_inr_s1;   // read index inside node range
	logic          in_acc, out_acc, obuf_free;

	assign out_acc   = ov_q && out_ready;
	// room when no result is parked or it leaves now, and no read in flight
	assign obuf_free = (!ov_q || out_ready) && !rd_pend_s1;
	assign in_ready  = (state_q == ST_RUN) && obuf_free;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = ov_q;

	// saturated load value
	logic [W-1:0] load_w;
	always_comb begin
		logic [FREQ_BITS-1:0] f;
		f = frequency;
		if (FREQ_BITS > W) begin
			load_w = (f > FREQ_BITS'(WMAX)) ? WMAX : W'(f);
		end else begin
			load_w = W'(f);
		end
	end

	// saturated merge sum
	logic [W:0] sum_full;
	assign sum_full = {1'b0, w1_q} + {1'b0, w2_q};

	logic scan_done;
	assign scan_done = (cnt_q == slot_q) && !rd_v_s1;

	always_comb begin
		w_we = 1'b0; w_wa = '0; w_wd = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0;
		w_ra = node_id[AW-1:0];
		l_ra = node_id[AW-1:0];
		unique case (state_q)
			ST_INIT: begin
				w_we = 1'b1; w_wa = cnt_q[AW-1:0];
				l_we = 1'b1; l_wa = cnt_q[AW-1:0];
			end
			ST_RUN: begin
				if (in_acc && operation == OP_LOAD
				    && {7'd0, node_id} < 16'(SYMBOLS)) begin
					w_we = 1'b1; w_wa = node_id[AW-1:0]; w_wd = load_w;
				end
			end
			ST_CLR: begin
				l_we = 1'b1; l_wa = cnt_q[AW-1:0];
				if (cnt_q >= CW'(SYMBOLS)) begin
					w_we = 1'b1; w_wa = cnt_q[AW-1:0];
				end
			end
			ST_SCAN: begin
				w_ra = cnt_q[AW-1:0];
			end
			ST_M0: begin
				w_we = 1'b1; w_wa = slot_q[AW-1:0];
				w_wd = sum_full[W] ? WMAX : sum_full[W-1:0];
				l_we = 1'b1; l_wa = slot_q[AW-1:0];
				l_wd.left = IDX_W'(i1_q); l_wd.right = IDX_W'(i2_q);
				l_wd.internal = 1'b1;
				l_ra = i1_q;
			end
			ST_M1: begin
				w_we = 1'b1; w_wa = i1_q;
				l_we = 1'b1; l_wa = i1_q;
				l_ra = i2_q;
			end
			ST_M2: begin
				w_we = 1'b1; w_wa = i2_q;
				l_we = 1'b1; l_wa = i2_q;
			end
			ST_RPT: ;
			default: ;
		endcase
		// child writes keep the entry's own child fields (read in the previous state)
		if (state_q == ST_M1 || state_q == ST_M2) begin
			l_wd = l_rd;
			l_wd.parent = IDX_W'(slot_q);
			l_wd.has_parent = 1'b1;
			l_wd.side = (state_q == ST_M2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= '0;
			slot_q     <= CW'(SYMBOLS);
			merged_q   <= 1'b0;
			rd_v_s1    <= 1'b0;
			f1_q       <= 1'b0;
			f2_q       <= 1'b0;
			ov_q       <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (out_acc) ov_q <= 1'b0;
			if (rd_pend_s1) begin
				rd_pend_s1 <= 1'b0;
				ov_q       <= 1'b1;
			end
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NODES - 1)) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (in_acc) begin
						if (operation == OP_READ) begin
							rd_pend_s1 <= 1'b1;
						end else if (last) begin
							state_q <= ST_CLR;
							cnt_q   <= '0;
						end
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NODES - 1)) begin
						state_q  <= ST_SCAN;
						cnt_q    <= '0;
						slot_q   <= CW'(SYMBOLS);
						merged_q <= 1'b0;
						f1_q <= 1'b0; f2_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cnt_q != slot_q) begin
						cnt_q   <= cnt_q + 1'b1;
						rd_v_s1 <= 1'b1;
						rd_a_s1 <= cnt_q[AW-1:0];
					end
					if (rd_v_s1 && w_rd != '0) begin
						if (!f1_q) begin
							w1_q <= w_rd; i1_q <= rd_a_s1; f1_q <= 1'b1;
						end else if (w_rd <= w1_q) begin
							w2_q <= w1_q; i2_q <= i1_q; f2_q <= 1'b1;
							w1_q <= w_rd; i1_q <= rd_a_s1;
						end else if (!f2_q || w_rd <= w2_q) begin
							w2_q <= w_rd; i2_q <= rd_a_s1; f2_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= (f1_q && f2_q) ? ST_M0 : ST_RPT;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					merged_q <= 1'b1;
					root_q   <= slot_q[AW-1:0];
					slot_q   <= slot_q + 1'b1;
					cnt_q    <= '0;
					f1_q <= 1'b0; f2_q <= 1'b0;
					state_q  <= (slot_q == CW'(NODES - 1)) ? ST_RPT : ST_SCAN;
				end
				ST_RPT: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && in_acc && operation == OP_READ) begin
			rd_inr_s1 <= {7'd0, node_id} < 16'(NODES);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			kind           <= KIND_NODE;
			tree_valid     <= 1'b0;
			root_index     <= '0;
			has_children   <= rd_inr_s1 && l_rd.internal;
			left_child     <= (rd_inr_s1 && l_rd.internal) ? l_rd.left : '0;
			right_child    <= (rd_inr_s1 && l_rd.internal) ? l_rd.right : '0;
			has_parent     <= rd_inr_s1 && l_rd.has_parent;
			parent_index   <= (rd_inr_s1 && l_rd.has_parent) ? l_rd.parent : '0;
			is_right_child <= rd_inr_s1 && l_rd.has_parent && l_rd.side;
			node_weight    <= rd_inr_s1 ? WOUT_W'(w_rd) : '0;
		end else if (state_q == ST_RPT && (!ov_q || out_ready)) begin
			kind           <= KIND_BUILD;
			tree_valid     <= merged_q;
			root_index     <= merged_q ? IDX_W'(root_q) : '0;
			has_children   <= 1'b0;
			left_child     <= '0;
			right_child    <= '0;
			has_parent     <= 1'b0;
			parent_index   <= '0;
			is_right_child <= 1'b0;
			node_weight    <= '0;
		end
	end

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == ST_RUN)
		else $error("beat accepted while building");
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> ov_q)
		else $error("read result lost");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= CW'(NODES))
		else $error("node slot overran");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q && $stable(kind) && $stable(root_index))
		else $error("result changed while stalled");
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for huffman_tree_builder: random and directed loads,
// builds and node reads, checked against an in-bench tree predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import htb_pkg::*;

	localparam int NSYM  = SYMBOLS_DEF;
	localparam int NNODE = 2 * SYMBOLS_DEF;
	localparam logic [WOUT_W-1:0] WMAX = {WOUT_W{1'b1}};

	// one result beat, all fields
	typedef struct {
		logic              kind;
		logic              tree_valid;
		logic [IDX_W-1:0]  root_index;
		logic [IDX_W-1:0]  left_child;
		logic [IDX_W-1:0]  right_child;
		logic              has_children;
		logic [IDX_W-1:0]  parent_index;
		logic              has_parent;
		logic              is_right_child;
		logic [WOUT_W-1:0] node_weight;
	} beat_t;

	// Tree predictor plus queue of expected beats
	class tree_scoreboard;
		logic [WOUT_W-1:0] weight[NNODE];
		logic [IDX_W-1:0]  lchild[NNODE];
		logic [IDX_W-1:0]  rchild[NNODE];
		logic [IDX_W-1:0]  par[NNODE];
		bit                par_ok[NNODE];
		bit                side[NNODE];
		bit                internal[NNODE];
		int                next_slot;
		beat_t             expected[$];
		int                errors;

		function new();
			for (int i = 0; i < NNODE; i++) begin
				weight[i] = '0; lchild[i] = '0; rchild[i] = '0; par[i] = '0;
				par_ok[i] = 0; side[i] = 0; internal[i] = 0;
			end
			next_slot = NSYM;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// repeated merge of the two smallest nonzero weights
		function void build_tree(output bit merged, output logic [IDX_W-1:0] root);
			logic [WOUT_W-1:0] w1, w2, w;
			logic [WOUT_W:0]   sum;
			int i1, i2;
			bit f1, f2;
			merged = 0;
			root = '0;
			for (int i = 0; i < NNODE; i++) begin
				par[i] = '0; par_ok[i] = 0; side[i] = 0;
				if (i >= NSYM) begin
					weight[i] = '0; lchild[i] = '0; rchild[i] = '0; internal[i] = 0;
				end
			end
			next_slot = NSYM;
			while (next_slot < NNODE) begin
				f1 = 0; f2 = 0; w1 = '0; w2 = '0; i1 = 0; i2 = 0;
				for (int j = 0; j < next_slot; j++) begin
					w = weight[j];
					if (w == 0) continue;
					if (!f1) begin
						w1 = w; i1 = j; f1 = 1;
					end else if (w <= w1) begin
						// tie with smallest: later index wins
						w2 = w1; i2 = i1; f2 = 1;
						w1 = w; i1 = j;
					end else if (!f2 || w <= w2) begin
						w2 = w; i2 = j; f2 = 1;
					end
				end
				if (!f1 || !f2) break;
				sum = {1'b0, w1} + {1'b0, w2};
				weight[next_slot] = (sum > {1'b0, WMAX}) ? WMAX : sum[WOUT_W-1:0];
				lchild[next_slot] = i1[IDX_W-1:0];
				rchild[next_slot] = i2[IDX_W-1:0];
				internal[next_slot] = 1;
				par[i1] = next_slot[IDX_W-1:0]; par_ok[i1] = 1; side[i1] = 0;
				par[i2] = next_slot[IDX_W-1:0]; par_ok[i2] = 1; side[i2] = 1;
				weight[i1] = '0;
				weight[i2] = '0;
				root = next_slot[IDX_W-1:0];
				merged = 1;
				next_slot++;
			end
		endfunction

		// accepted input beat
		function void note(input logic op, input logic [IDX_W-1:0] idx,
				input logic [FREQ_W-1:0] freq, input logic lst);
			beat_t e;
			bit ok;
			logic [IDX_W-1:0] root;
			e = '{default: '0};
			if (op == OP_LOAD) begin
				if (idx < NSYM) weight[idx] = WOUT_W'(freq);
				if (!lst) return;
				build_tree(ok, root);
				e.kind = KIND_BUILD;
				e.tree_valid = ok;
				e.root_index = ok ? root : '0;
			end else begin
				e.kind = KIND_NODE;
				if (idx < NNODE) begin
					if (internal[idx]) begin
						e.left_child = lchild[idx];
						e.right_child = rchild[idx];
						e.has_children = 1;
					end
					if (par_ok[idx]) begin
						e.parent_index = par[idx];
						e.has_parent = 1;
						e.is_right_child = side[idx];
					end
					e.node_weight = weight[idx];
				end
			end
			expected.push_back(e);
		endfunction

		task cmp(input string name, input logic [63:0] got, input logic [63:0] exp);
			if (got !== exp) report($sformatf("%s got %0h exp %0h", name, got, exp));
		endtask

		task check(input beat_t got);
			beat_t e;
			if (expected.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			e = expected.pop_front();
			cmp("kind", 64'(got.kind), 64'(e.kind));
			cmp("tree_valid", 64'(got.tree_valid), 64'(e.tree_valid));
			cmp("root_index", 64'(got.root_index), 64'(e.root_index));
			cmp("left_child", 64'(got.left_child), 64'(e.left_child));
			cmp("right_child", 64'(got.right_child), 64'(e.right_child));
			cmp("has_children", 64'(got.has_children), 64'(e.has_children));
			cmp("parent_index", 64'(got.parent_index), 64'(e.parent_index));
			cmp("has_parent", 64'(got.has_parent), 64'(e.has_parent));
			cmp("is_right_child", 64'(got.is_right_child), 64'(e.is_right_child));
			cmp("node_weight", 64'(got.node_weight), 64'(e.node_weight));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              operation;
	logic [IDX_W-1:0]  node_id;
	logic [FREQ_W-1:0] frequency;
	logic              last;
	logic              out_valid;
	logic              out_ready;
	logic              kind;
	logic              tree_valid;
	logic [IDX_W-1:0]  root_index;
	logic [IDX_W-1:0]  left_child;
	logic [IDX_W-1:0]  right_child;
	logic              has_children;
	logic [IDX_W-1:0]  parent_index;
	logic              has_parent;
	logic              is_right_child;
	logic [WOUT_W-1:0] node_weight;

	tree_scoreboard sb;
	bit quiet;      // no idling on either side
	int hold_req;   // receiver hold-off length, picked up by the receiver
	int items;

	huffman_tree_builder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .node_id(node_id),
		.frequency(frequency), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .tree_valid(tree_valid), .root_index(root_index),
		.left_child(left_child), .right_child(right_child),
		.has_children(has_children), .parent_index(parent_index),
		.has_parent(has_parent), .is_right_child(is_right_child),
		.node_weight(node_weight)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[huffman_tree_builder] ERROR");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int cnt;
		cnt = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				cnt = hold_req;
				hold_req = 0;
			end
			if (cnt > 0) begin
				out_ready <= 0;
				cnt--;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 21);
			end
		end
	end

	// result monitor; values read here are the pre-edge ones
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check('{kind, tree_valid, root_index, left_child, right_child,
				has_children, parent_index, has_parent, is_right_child, node_weight});
		end
	end

	// one input beat, with random idle cycles in front
	task send(input logic op, input logic [IDX_W-1:0] idx,
			input logic [FREQ_W-1:0] freq, input logic lst);
		while (!quiet && $urandom_range(99) < 21) begin
			in_valid <= 0;
			@(posedge clk);
		end
		operation <= op;
		node_id <= idx;
		frequency <= freq;
		last <= lst;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note(op, idx, freq, lst);
		items++;
	endtask

	function logic [FREQ_W-1:0] pick_freq(input int mode);
		case (mode)
			0: pick_freq = $urandom;
			1: pick_freq = $urandom_range(4, 1);   // lots of ties
			2: pick_freq = {FREQ_W{1'b1}} - $urandom_range(3);
			default: pick_freq = ($urandom_range(3) == 0) ? '0 : $urandom_range(1000);
		endcase
	endfunction

	// read a spread of nodes: leaves, the fresh internal region, anywhere
	task read_nodes(input int n);
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: idx = IDX_W'($urandom_range(NSYM - 1));
				1: idx = IDX_W'(NSYM + $urandom_range(15));
				2: idx = sb.next_slot > NSYM ?
					IDX_W'(sb.next_slot - 1 - $urandom_range(2)) : IDX_W'(NSYM);
				default: idx = IDX_W'($urandom);
			endcase
			send(OP_READ, idx, $urandom, 1'($urandom_range(1)));
		end
	endtask

	// a few symbol loads closed by a last load, then some reads
	task small_set(input int k, input int mode);
		for (int i = 0; i < k; i++)
			send(OP_LOAD, IDX_W'($urandom_range(NSYM - 1)), pick_freq(mode), 0);
		if ($urandom_range(9) == 0)
			send(OP_LOAD, IDX_W'(NSYM + $urandom_range(NNODE - NSYM - 1)), $urandom, 1);
		else
			send(OP_LOAD, IDX_W'($urandom_range(NSYM - 1)), pick_freq(mode), 1);
		read_nodes($urandom_range(12, 2));
	endtask

	task full_set(input int mode);
		for (int i = 0; i < NSYM; i++)
			send(OP_LOAD, IDX_W'(i), pick_freq(mode), i == NSYM - 1);
		read_nodes(20);
	endtask

	initial begin
		sb = new();
		quiet = 0;
		hold_req = 0;
		items = 0;
		arst_n = 0;
		in_valid = 0;
		operation = OP_LOAD;
		node_id = '0;
		frequency = '0;
		last = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: empty build, lone leaf, ignored loads, ties, extremes
		send(OP_LOAD, 0, 0, 1);
		send(OP_READ, 0, 0, 0);
		send(OP_LOAD, 255, {FREQ_W{1'b1}}, 1);      // single leaf, no merge
		send(OP_LOAD, 511, {FREQ_W{1'b1}}, 0);      // beyond symbols, dropped
		send(OP_LOAD, 256, 5, 1);                   // beyond symbols, still builds
		send(OP_LOAD, 0, {FREQ_W{1'b1}}, 0);
		send(OP_LOAD, 1, 3, 0);
		send(OP_LOAD, 2, 3, 0);                     // tie with smallest
		send(OP_LOAD, 3, 3, 1);
		send(OP_READ, 0, {FREQ_W{1'b1}}, 1);        // read ignores last and freq
		send(OP_READ, 1, 0, 0);
		send(OP_READ, 2, 0, 0);
		send(OP_READ, 3, 0, 0);
		send(OP_READ, 255, 0, 0);
		send(OP_READ, 256, 0, 1);
		send(OP_READ, 257, 0, 0);
		send(OP_READ, 258, 0, 0);
		send(OP_READ, 511, 0, 0);
		send(OP_LOAD, 10, 7, 0);
		send(OP_LOAD, 11, 9, 0);
		send(OP_LOAD, 12, 9, 1);                    // tie with second
		send(OP_READ, 256, 0, 0);
		send(OP_READ, 257, 0, 0);

		// two full trees, one with heavy ties, one with large weights
		full_set(1);
		full_set(2);

		// long idle-free stretch, with a receiver hold-off to back up the input
		quiet = 1;
		hold_req = 400;
		read_nodes(60);
		small_set(6, 0);
		quiet = 0;

		while (items < 800)
			small_set($urandom_range(8), $urandom_range(3));

		@(posedge clk);
		in_valid <= 0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[huffman_tree_builder] OK");
		end else begin
			$display("[huffman_tree_builder] ERROR");
		end
		$finish;
	end
endmodule
